// File: hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers; they expand to nothing in synthesis builds.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
// Clocked assertion that is switched off while reset is asserted (active low).
`define STCI_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// Clocked assertion that is checked on every edge, reset included.
`define STCI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define STCI_ASSERT(lbl, clk, rst_n, prop, msg)
`define STCI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// File: hw/rtl/stci_pkg.sv
// ----------------------------------------------------------------------------
// stci_pkg
// Types, the quarter-wave sine table and Q15 saturating arithmetic helpers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package stci_pkg;

    typedef logic signed [15:0] t_q15;
    typedef logic        [14:0] t_frac;

    localparam int TABLE_DEPTH = 128;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int FRAC_W      = 8;

    localparam logic [IDX_W-1:0] QUARTER_IDX = IDX_W'(TABLE_DEPTH / 4);
    localparam t_q15             SLOPE_SCALE = 16'sd1608;
    localparam t_q15             Q15_MAX     = 16'sh7fff;
    localparam t_q15             Q15_MIN     = 16'sh8000;

    // First quarter of the sine wave, entries 0 through 32 inclusive.
    localparam t_q15 QUARTER_ROM [33] = '{
        16'sd0,     16'sd1608,  16'sd3212,  16'sd4808,
        16'sd6393,  16'sd7962,  16'sd9512,  16'sd11039,
        16'sd12539, 16'sd14010, 16'sd15446, 16'sd16846,
        16'sd18204, 16'sd19519, 16'sd20787, 16'sd22005,
        16'sd23170, 16'sd24279, 16'sd25329, 16'sd26319,
        16'sd27245, 16'sd28105, 16'sd28898, 16'sd29621,
        16'sd30273, 16'sd30852, 16'sd31356, 16'sd31785,
        16'sd32137, 16'sd32412, 16'sd32609, 16'sd32728,
        16'sd32767
    };

    // Full-period table read built from quarter-wave symmetry.
    function automatic t_q15 rom_read(input logic [IDX_W-1:0] idx);
        logic [5:0] q;
        t_q15       v;
        q = idx[5:0];
        if (q <= 6'd32) begin
            v = QUARTER_ROM[q];
        end else begin
            v = QUARTER_ROM[6'(7'd64 - {1'b0, q})];
        end
        return idx[6] ? -v : v;
    endfunction

    function automatic t_q15 sat_q15(input logic signed [17:0] v);
        if (v > 18'sd32767) begin
            return Q15_MAX;
        end else if (v < -18'sd32768) begin
            return Q15_MIN;
        end
        return v[15:0];
    endfunction

    function automatic t_q15 q_add(input t_q15 x, input t_q15 y);
        logic signed [17:0] s;
        s = 18'(x) + 18'(y);
        return sat_q15(s);
    endfunction

    function automatic t_q15 q_sub(input t_q15 x, input t_q15 y);
        logic signed [17:0] s;
        s = 18'(x) - 18'(y);
        return sat_q15(s);
    endfunction

    function automatic t_q15 q_dbl(input t_q15 x);
        logic signed [17:0] s;
        s = 18'(x) + 18'(x);
        return sat_q15(s);
    endfunction

    function automatic t_q15 q_tri(input t_q15 x);
        logic signed [17:0] s;
        s = 18'(x) + 18'(x) + 18'(x);
        return sat_q15(s);
    endfunction

    // Q15 product, floored by an arithmetic shift, then saturated.
    function automatic t_q15 q_mul(input t_q15 x, input t_q15 y);
        logic signed [31:0] p;
        logic signed [17:0] s;
        p = 32'(x) * 32'(y);
        s = 18'(p >>> 15);
        return sat_q15(s);
    endfunction

endpackage

// File: hw/rtl/sine_table_cubic_interp_unit.sv
// ----------------------------------------------------------------------------
// sine_table_cubic_interp_unit
// Q15 sine of a per-unit-turn angle by table lookup and cubic Hermite interpolation.
// A request passes through six register stages, stage 1 to stage 6, and leaves on
// o_valid/o_sine from the last. Throughput: one request per clock while the output is not stalled; each of the six
// register stages takes a new request whenever it is empty or the stage after it moves.
// Reset: synchronous, active low; clears every stage valid bit, data is not reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "assert_macros.svh"

module sine_table_cubic_interp_unit import stci_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic signed [15:0] i_angle,
    output logic        o_valid,
    input  logic        i_stall,
    output logic signed [15:0] o_sine
);

    localparam int STAGES = 6;

    // One valid bit per stage. A stage advances when it is empty or when the
    // stage after it advances, so bubbles are squeezed out under a stall.
    logic [STAGES-1:0] r_vld;
    logic [STAGES-1:0] w_adv;

    assign w_adv[STAGES-1] = !r_vld[STAGES-1] || !i_stall;

    genvar g;
    generate
        for (g = 0; g < STAGES - 1; g++) begin : g_adv
            assign w_adv[g] = !r_vld[g] || w_adv[g+1];
        end
    endgenerate

    assign o_stall = !w_adv[0];
    assign o_valid = r_vld[STAGES-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (w_adv[0]) r_vld[0] <= i_valid;
            if (w_adv[1]) r_vld[1] <= r_vld[0];
            if (w_adv[2]) r_vld[2] <= r_vld[1];
            if (w_adv[3]) r_vld[3] <= r_vld[2];
            if (w_adv[4]) r_vld[4] <= r_vld[3];
            if (w_adv[5]) r_vld[5] <= r_vld[4];
        end
    end

    // Stage 1: table reads. Bits 14:8 of the angle pick entry k, bits 7:0 are
    // the fraction. The cosine slopes come from the same table a quarter turn
    // away; the sign bit of the angle is ignored since a turn is 2^15.
    logic [IDX_W-1:0]  w_k0;
    logic [IDX_W-1:0]  w_k1;
    logic [IDX_W-1:0]  w_j0;
    logic [IDX_W-1:0]  w_j1;
    logic [FRAC_W-1:0] w_tf;

    assign w_k0 = i_angle[14:8];
    assign w_tf = i_angle[7:0];
    assign w_k1 = w_k0 + IDX_W'(1);
    assign w_j1 = QUARTER_IDX - w_k1;
    assign w_j0 = w_j1 + IDX_W'(1);

    t_q15              r1_f0, r1_f1, r1_c0, r1_c1;
    logic [FRAC_W-1:0] r1_tf;
    logic [15:0]       r1_tsq;

    always_ff @(posedge i_clk) begin
        if (w_adv[0]) begin
            r1_f0  <= rom_read(w_k0);
            r1_f1  <= rom_read(w_k1);
            r1_c0  <= rom_read(w_j0);
            r1_c1  <= rom_read(w_j1);
            r1_tf  <= w_tf;
            r1_tsq <= 16'(w_tf) * 16'(w_tf);
        end
    end

    // Stage 2: scale the slopes by 2*pi/128 and build the powers of t in Q15.
    logic [23:0] w_tcube;
    assign w_tcube = 24'(r1_tsq) * 24'(r1_tf);

    t_q15  r2_f0, r2_f1, r2_d0, r2_d1;
    t_frac r2_t1, r2_t2, r2_t3;

    always_ff @(posedge i_clk) begin
        if (w_adv[1]) begin
            r2_f0 <= r1_f0;
            r2_f1 <= r1_f1;
            r2_d0 <= q_mul(r1_c0, SLOPE_SCALE);
            r2_d1 <= q_mul(r1_c1, SLOPE_SCALE);
            r2_t1 <= {r1_tf, 7'b0};
            r2_t2 <= r1_tsq[15:1];
            r2_t3 <= w_tcube[23:9];
        end
    end

    // Stage 3: first half of the coefficient arithmetic; every step saturates.
    t_q15  r3_a2, r3_b3, r3_d02, r3_d0, r3_d1, r3_f0;
    t_frac r3_t1, r3_t2, r3_t3;

    always_ff @(posedge i_clk) begin
        if (w_adv[2]) begin
            r3_a2  <= q_dbl(q_sub(r2_f0, r2_f1));
            r3_b3  <= q_tri(q_sub(r2_f1, r2_f0));
            r3_d02 <= q_dbl(r2_d0);
            r3_d0  <= r2_d0;
            r3_d1  <= r2_d1;
            r3_f0  <= r2_f0;
            r3_t1  <= r2_t1;
            r3_t2  <= r2_t2;
            r3_t3  <= r2_t3;
        end
    end

    // Stage 4: finish the cubic and quadratic coefficients a and b.
    t_q15  r4_a, r4_b, r4_d0, r4_f0;
    t_frac r4_t1, r4_t2, r4_t3;

    always_ff @(posedge i_clk) begin
        if (w_adv[3]) begin
            r4_a  <= q_add(q_add(r3_d0, r3_a2), r3_d1);
            r4_b  <= q_sub(q_sub(r3_b3, r3_d02), r3_d1);
            r4_d0 <= r3_d0;
            r4_f0 <= r3_f0;
            r4_t1 <= r3_t1;
            r4_t2 <= r3_t2;
            r4_t3 <= r3_t3;
        end
    end

    // Stage 5: the three polynomial terms, one 16x16 product each.
    t_q15 r5_p3, r5_p2, r5_p1, r5_f0;

    always_ff @(posedge i_clk) begin
        if (w_adv[4]) begin
            r5_p3 <= q_mul(r4_a, {1'b0, r4_t3});
            r5_p2 <= q_mul(r4_b, {1'b0, r4_t2});
            r5_p1 <= q_mul(r4_d0, {1'b0, r4_t1});
            r5_f0 <= r4_f0;
        end
    end

    // Stage 6: sum the terms left to right with saturation into the output
    // register, which holds its value while the receiver stalls.
    t_q15 r_sine;

    always_ff @(posedge i_clk) begin
        if (w_adv[5]) begin
            r_sine <= q_add(q_add(q_add(r5_p3, r5_p2), r5_p1), r5_f0);
        end
    end

    assign o_sine = r_sine;

    // The input side only stalls when every stage holds a request.
    `STCI_ASSERT(a_stall_full, i_clk, i_rst_n, o_stall |-> (&r_vld), "stall with a bubble")
    // An accepted request always lands in the first stage.
    `STCI_ASSERT(a_accept_lands, i_clk, i_rst_n, (i_valid && !o_stall) |=> r_vld[0], "entry lost")
    // A request in stage five moves to the output unless the output is blocked.
    `STCI_ASSERT(a_last_moves, i_clk, i_rst_n, (r_vld[4] && w_adv[5]) |=> r_vld[5], "exit lost")

endmodule

// File: bench/sine_table_cubic_interp_unit_test.sv
// ----------------------------------------------------------------------------
// sine_table_cubic_interp_unit_test
// Self-checking bench for the table-based cubic Hermite sine unit. A queue of
// angle requests (a directed set of corner angles, then shaped random angles)
// feeds a clocked driver. A clocked monitor compares every sine that leaves
// the unit against a local bit-accurate model of the table lookup and
// interpolation. Both sides of the valid/stall handshake throttle at random until the last third of the requests.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sine_table_cubic_interp_unit_test import stci_pkg::*; ();

    // Run control. The cycle limit leaves a wide margin over the slowest correct run,
    // which comes with both sides throttling.
    localparam int RANDOM_REQUESTS = 1100;
    localparam int CYCLE_LIMIT     = 200000;
    localparam int SETTLE_CYCLES   = 16;

    // Sine slopes are scaled by 2*pi/128 in Q15.
    localparam int DERIV_SCALE = 1608;

    // First quarter of the sine wave, round(32767*sin(2*pi*k/128)) for k = 0..32.
    localparam int SINE_QUARTER [33] = '{
        0,     1608,  3212,  4808,  6393,  7962,  9512,  11039,
        12539, 14010, 15446, 16846, 18204, 19519, 20787, 22005,
        23170, 24279, 25329, 26319, 27245, 28105, 28898, 29621,
        30273, 30852, 31356, 31785, 32137, 32412, 32609, 32728,
        32767
    };

    // One entry of the stimulus queue. A drain marker carries no angle: the
    // driver holds off at it until every outstanding sine has come back.
    typedef struct {
        logic [15:0] angle;
        bit          drain_pause;
    } t_angle_request;

    logic               i_clk   = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic signed [15:0] i_angle = '0;
    logic               i_stall = 1'b0;
    logic               o_stall;
    logic               o_valid;
    logic signed [15:0] o_sine;

    t_angle_request pending_angles [$];
    t_q15           sine_expected [$];

    int total_requests = 0;
    int requests_sent  = 0;
    int sines_checked  = 0;
    int fail_count     = 0;
    int cycle_count    = 0;
    int send_idle_pct  = 28;
    int recv_idle_pct  = 55;

    sine_table_cubic_interp_unit DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .i_angle (i_angle),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .o_sine  (o_sine)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------------

    // Clamp any intermediate to the Q15 range.
    function automatic int q15_clamp(input longint v);
        if (v > 32767) begin
            return 32767;
        end
        if (v < -32768) begin
            return -32768;
        end
        return int'(v);
    endfunction

    // Full-period table entry, unfolded from the quarter wave. The index
    // wraps modulo the table depth.
    function automatic int sine_entry(input int idx);
        int wrapped;
        int fold;
        int mag;
        wrapped = idx & 127;
        fold    = wrapped & 63;
        mag     = (fold <= 32) ? SINE_QUARTER[fold] : SINE_QUARTER[64 - fold];
        return (wrapped >= 64) ? -mag : mag;
    endfunction

    // Q15 product, floored toward minus infinity, then clamped.
    function automatic int q15_product(input int x, input int y);
        longint prod;
        prod = longint'(x) * longint'(y);
        return q15_clamp(prod >>> 15);
    endfunction

    // Expected sine of one angle: table lookup plus cubic Hermite interpolation.
    function automatic t_q15 hermite_sine(input logic [15:0] angle);
        int seg;
        int frac;
        int frac_sq;
        int pow1;
        int pow2;
        int pow3;
        int next_seg;
        int slope_hi_idx;
        int slope_lo_idx;
        int y0;
        int y1;
        int m0;
        int m1;
        int coef_a;
        int coef_b;
        int acc;
        // Bit 15 is dropped: one full turn is 2^15, so negative angles alias.
        seg      = int'(angle[14:8]);
        frac     = int'(angle[7:0]);
        frac_sq  = frac * frac;
        pow1     = frac << 7;
        pow2     = frac_sq >> 1;
        pow3     = (frac_sq * frac) >> 9;
        next_seg = (seg + 1) & 127;
        // The cosine at a point is the sine of a quarter period minus that point,
        // read as 160 - k modulo the depth.
        slope_hi_idx = (160 - next_seg) & 127;
        slope_lo_idx = (slope_hi_idx + 1) & 127;
        y0 = sine_entry(seg);
        y1 = sine_entry(next_seg);
        m1 = q15_product(sine_entry(slope_hi_idx), DERIV_SCALE);
        m0 = q15_product(sine_entry(slope_lo_idx), DERIV_SCALE);
        coef_a = q15_clamp(y0 - y1);
        coef_a = q15_clamp(m0 + q15_clamp(2 * coef_a));
        coef_a = q15_clamp(coef_a + m1);
        coef_b = q15_clamp(y1 - y0);
        coef_b = q15_clamp(3 * coef_b);
        coef_b = q15_clamp(coef_b - q15_clamp(2 * m0));
        coef_b = q15_clamp(coef_b - m1);
        acc = q15_product(coef_a, pow3);
        acc = q15_clamp(acc + q15_product(coef_b, pow2));
        acc = q15_clamp(acc + q15_product(m0, pow1));
        acc = q15_clamp(acc + y0);
        return t_q15'(acc);
    endfunction

    // ------------------------------------------------------------------------
    // Driver
    // ------------------------------------------------------------------------
    // A request is accepted at an edge where i_valid is high and o_stall is
    // low. The driver only moves to the next request once the current one is
    // gone, so a stalled angle stays put and valid is never withdrawn. The
    // idle rates follow three phases over the run: sender idles 28 percent
    // and receiver 55, then the rates swap, then neither side idles.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                sine_expected.push_back(hermite_sine(i_angle));
                requests_sent++;
            end
            if (requests_sent < total_requests / 3) begin
                send_idle_pct <= 28;
                recv_idle_pct <= 55;
            end else if (requests_sent < (2 * total_requests) / 3) begin
                send_idle_pct <= 55;
                recv_idle_pct <= 28;
            end else begin
                send_idle_pct <= 0;
                recv_idle_pct <= 0;
            end
            if (!i_valid || !o_stall) begin
                if (pending_angles.size() > 0 && pending_angles[0].drain_pause) begin
                    // Hold off until the pipeline has handed back every sine.
                    if (sine_expected.size() == 0) begin
                        pending_angles.pop_front();
                    end
                    i_valid <= 1'b0;
                end else if (pending_angles.size() > 0 &&
                             $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_angle <= pending_angles[0].angle;
                    pending_angles.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Monitor
    // ------------------------------------------------------------------------
    // Every accepted sine is checked against the oldest prediction. The
    // receiver stall is redrawn every cycle at the current phase's rate.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else begin
            if (o_valid && !i_stall) begin
                if (sine_expected.size() == 0) begin
                    $display("%0t: unexpected sine %0d with no request outstanding",
                             $time, o_sine);
                    fail_count++;
                end else begin
                    if (o_sine !== sine_expected[0]) begin
                        $display("%0t: sine mismatch, expected %0d, actual %0d",
                                 $time, sine_expected[0], o_sine);
                        fail_count++;
                    end
                    sine_expected.pop_front();
                    sines_checked++;
                end
            end
            i_stall <= ($urandom_range(99) < recv_idle_pct);
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Queue one angle request.
    task automatic queue_angle(input logic [15:0] angle);
        t_angle_request req;
        req.angle       = angle;
        req.drain_pause = 1'b0;
        pending_angles.push_back(req);
        total_requests++;
    endtask

    // Queue a hold-off point at which the sender waits for the pipeline to empty.
    task automatic queue_drain();
        t_angle_request req;
        req.angle       = '0;
        req.drain_pause = 1'b1;
        pending_angles.push_back(req);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus and end of run
    // ------------------------------------------------------------------------
    initial begin
        logic [15:0] angle;
        int          kind;

        // Directed corners: zero, quarter and half turns, both ends of the
        // fraction, the last table segment whose neighbor wraps to entry zero,
        // and negative angles that alias onto the same point of the period.
        queue_angle(16'h0000);
        queue_angle(16'h0001);
        queue_angle(16'h0080);
        queue_angle(16'h00ff);
        queue_angle(16'h0100);
        queue_angle(16'h1fff);
        queue_angle(16'h2000);
        queue_angle(16'h20ff);
        queue_angle(16'h3fff);
        queue_angle(16'h4000);
        queue_angle(16'h5fff);
        queue_angle(16'h6000);
        queue_angle(16'h7eff);
        queue_angle(16'h7f00);
        queue_angle(16'h7f80);
        queue_angle(16'h7fff);
        queue_angle(16'h8000);
        queue_angle(16'h80ff);
        queue_angle(16'ha0ff);
        queue_angle(16'hc000);
        queue_angle(16'he000);
        queue_angle(16'hff00);
        queue_angle(16'hffff);
        queue_angle(16'h3f7f);
        queue_drain();

        // Random angles. Most are uniform over all 16 bits; the rest lean on
        // fraction ends, segments next to the wrap and quarter points, and
        // small fractions where the cubic terms are tiny.
        for (int n = 0; n < RANDOM_REQUESTS; n++) begin
            kind  = $urandom_range(9);
            angle = 16'($urandom);
            case (kind)
                6: begin
                    angle[7:0] = ($urandom_range(1) != 0) ? 8'hff : 8'h00;
                end
                7: begin
                    case ($urandom_range(3))
                        0: angle[14:8] = 7'd127;
                        1: angle[14:8] = 7'd31;
                        2: angle[14:8] = 7'd63;
                        default: angle[14:8] = 7'd95;
                    endcase
                end
                8: begin
                    angle[7:0] = 8'($urandom_range(3));
                end
                default: begin
                end
            endcase
            queue_angle(angle);
            if (n == RANDOM_REQUESTS / 2) begin
                queue_drain();
            end
        end

        // Reset is held low for a while and released on a rising edge.
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Wait until every request has been accepted, then for its sine.
        wait (requests_sent == total_requests);
        @(posedge i_clk);
        wait (sine_expected.size() == 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (fail_count == 0 && sine_expected.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
